>>> rtl/tobb_pkg.sv
// Shared types and constants for the triangle versus box overlap block.
`timescale 1ns / 1ps

package tobb_pkg;

    // Width of one matrix or translation coefficient word
    localparam int COEF_W = 32;

    // Configuration port widths
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_COEF_PAIR_0 = 3'd0,
        CFG_COEF_PAIR_1 = 3'd1,
        CFG_COEF_PAIR_2 = 3'd2,
        CFG_COEF_PAIR_3 = 3'd3,
        CFG_COEF_PAIR_4 = 3'd4,
        CFG_COEF_PAIR_5 = 3'd5,
        CFG_QUICK_MODE  = 3'd6
    } cfg_index_e;

    // Inverse box transform, row-vector convention
    typedef struct packed {
        logic signed [COEF_W-1:0] m11;
        logic signed [COEF_W-1:0] m12;
        logic signed [COEF_W-1:0] m13;
        logic signed [COEF_W-1:0] m21;
        logic signed [COEF_W-1:0] m22;
        logic signed [COEF_W-1:0] m23;
        logic signed [COEF_W-1:0] m31;
        logic signed [COEF_W-1:0] m32;
        logic signed [COEF_W-1:0] m33;
        logic signed [COEF_W-1:0] tx;
        logic signed [COEF_W-1:0] ty;
        logic signed [COEF_W-1:0] tz;
    } coef_t;

endpackage

>>> rtl/tobb_fifo.sv
// Short word queue between the front and back parts.
`timescale 1ns / 1ps

module tobb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNTW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/tobb_front.sv
// Front part: maps vertices into box space and classifies the face planes.
`timescale 1ns / 1ps

module tobb_front #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [8:0][COORD_WIDTH-1:0]     vtx,
    input  tobb_pkg::coef_t                 coef,
    output logic                            push_valid,
    input  logic                            push_ready,
    output logic [9*COORD_WIDTH:0]          push_data
);

    localparam int CW  = COORD_WIDTH;
    localparam int PW  = CW + tobb_pkg::COEF_W;
    localparam int SW  = PW + 3;
    localparam int NCW = ((CW > FRAC_BITS + 1) ? CW : FRAC_BITS + 2) + 1;
    localparam logic signed [NCW-1:0] ONE_N =
        {{(NCW - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

    logic signed [tobb_pkg::COEF_W-1:0] mc [3][3];
    logic signed [tobb_pkg::COEF_W-1:0] tv [3];
    logic signed [PW-1:0]               prod_reg [9][3];
    logic [8:0][CW-1:0]                 v_reg, v_next;
    logic                               s1_valid_reg, s2_valid_reg;
    logic                               adv;
    logic                               face_sep;
    logic signed [SW-1:0]               acc [9];

    // Saturate a mapped coordinate to the coordinate range
    function automatic logic [CW-1:0] sat_coord(input logic signed [SW-1:0] val);
        logic [SW-CW:0] upper;
        upper = val[SW-1:CW-1];
        if (upper == '0 || upper == '1)
            return val[CW-1:0];
        else if (val[SW-1])
            return {1'b1, {(CW-1){1'b0}}};
        else
            return {1'b0, {(CW-1){1'b1}}};
    endfunction

    assign adv        = !s2_valid_reg || push_ready;
    assign in_ready   = adv;
    assign push_valid = s2_valid_reg;
    assign push_data  = {face_sep, v_reg};

    // Arrange coefficients by input row and output column
    always_comb
    begin
        mc[0][0] = coef.m11; mc[0][1] = coef.m12; mc[0][2] = coef.m13;
        mc[1][0] = coef.m21; mc[1][1] = coef.m22; mc[1][2] = coef.m23;
        mc[2][0] = coef.m31; mc[2][1] = coef.m32; mc[2][2] = coef.m33;
        tv[0] = coef.tx; tv[1] = coef.ty; tv[2] = coef.tz;
    end

    // Sum products, floor to the coordinate format, translate and saturate
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                acc[3*k+j] = (SW'(prod_reg[3*k+j][0]) + SW'(prod_reg[3*k+j][1])
                             + SW'(prod_reg[3*k+j][2])) >>> FRAC_BITS;
                v_next[3*k+j] = sat_coord(acc[3*k+j] + SW'(tv[j]));
            end
        end
    end

    // Face planes separate when all three vertices lie strictly beyond one
    always_comb
    begin
        face_sep = 1'b0;
        for (int j = 0; j < 3; j++)
        begin
            if ((NCW'($signed(v_reg[j])) < -ONE_N) && (NCW'($signed(v_reg[3+j])) < -ONE_N)
                && (NCW'($signed(v_reg[6+j])) < -ONE_N))
                face_sep = 1'b1;
            if ((NCW'($signed(v_reg[j])) > ONE_N) && (NCW'($signed(v_reg[3+j])) > ONE_N)
                && (NCW'($signed(v_reg[6+j])) > ONE_N))
                face_sep = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Hold products and mapped vertices while the queue is full
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
                for (int j = 0; j < 3; j++)
                    for (int r = 0; r < 3; r++)
                        prod_reg[3*k+j][r] <= $signed(vtx[3*k+r]) * mc[r][j];
            v_reg <= v_next;
        end
    end

endmodule

>>> rtl/tobb_back.sv
// Back part: triangle plane and edge axis tests, result register.
`timescale 1ns / 1ps

module tobb_back #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pop_valid,
    output logic                   pop_ready,
    input  logic [9*COORD_WIDTH:0] pop_data,
    input  logic                   quick,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   overlap
);

    localparam int CW  = COORD_WIDTH;
    localparam int EW  = CW + 1;
    localparam int NW  = 2 * EW + 1;
    localparam int L   = (NW + 1) / 2;
    localparam int HW  = NW - L;
    localparam int EPW = EW + CW;
    localparam int RW  = EW + 1;
    localparam int XW  = EW + ((CW > FRAC_BITS) ? CW : FRAC_BITS) + 3;
    localparam int NCW = ((CW > FRAC_BITS + 1) ? CW : FRAC_BITS + 2) + 1;
    localparam int PLW = NCW + L + 1;
    localparam int PHW = NCW + HW;
    localparam int DW  = NCW + NW + 1;
    localparam int DSW = DW + 2;
    localparam logic signed [NCW-1:0] ONE_N =
        {{(NCW - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

    // Per box axis j: components of a and b, their negation, vertex indexes
    localparam int CA [3] = '{2, 2, 1};
    localparam int CB [3] = '{1, 0, 0};
    localparam int NA [3] = '{0, 1, 0};
    localparam int NB [3] = '{1, 0, 1};
    localparam int I0 [3] = '{1, 0, 0};
    localparam int I1 [3] = '{2, 2, 1};

    logic adv;

    // Stage 1: vertices and edges
    logic                 b1_valid_reg;
    logic                 face1_reg;
    logic signed [CW-1:0] v1_reg [9];
    logic signed [EW-1:0] e1_reg [3][3];
    logic signed [CW-1:0] vin [9];
    logic signed [EW-1:0] e_next [3][3];

    // Stage 2: products
    logic                  b2_valid_reg;
    logic                  face2_reg;
    logic signed [CW-1:0]  v0_2_reg [3];
    logic signed [2*EW-1:0] np_reg [6];
    logic signed [EPW-1:0] ep_reg [9][4];
    logic signed [RW-1:0]  rad_reg [9];
    logic signed [EW-1:0]  a_sel [9];
    logic signed [EW-1:0]  b_sel [9];
    logic signed [EW-1:0]  fa [9];
    logic signed [EW-1:0]  fb [9];
    logic [1:0]            pv [9];
    logic [1:0]            qv [9];

    // Stage 3: normal and edge axis result
    logic                 b3_valid_reg;
    logic                 face3_reg;
    logic                 esep3_reg;
    logic signed [CW-1:0] v0_3_reg [3];
    logic signed [NW-1:0] n3_reg [3];
    logic signed [NW-1:0] n_next [3];
    logic                 esep_next;
    logic signed [XW-1:0] s0 [9];
    logic signed [XW-1:0] s1 [9];
    logic signed [XW-1:0] rx [9];

    // Stage 4: plane partial products
    logic                  b4_valid_reg;
    logic                  face4_reg;
    logic                  esep4_reg;
    logic signed [PLW-1:0] pl_reg [3][2];
    logic signed [PHW-1:0] ph_reg [3][2];
    logic signed [NCW-1:0] cor [3][2];

    // Stage 5: plane dot products
    logic                  b5_valid_reg;
    logic                  face5_reg;
    logic                  esep5_reg;
    logic signed [DSW-1:0] dmin_reg, dmax_reg;
    logic signed [DSW-1:0] dmin_next, dmax_next;

    // Output register
    logic out_valid_reg;
    logic overlap_reg;
    logic overlap_next;

    assign adv       = !out_valid_reg || out_ready;
    assign pop_ready = adv;
    assign out_valid = out_valid_reg;
    assign overlap   = overlap_reg;

    // Unpack vertices and form the edges b - a, c - b and a - c
    always_comb
    begin
        for (int i = 0; i < 9; i++)
            vin[i] = $signed(pop_data[i*CW +: CW]);
        for (int i = 0; i < 3; i++)
        begin
            e_next[0][i] = EW'(vin[3+i]) - EW'(vin[i]);
            e_next[1][i] = EW'(vin[6+i]) - EW'(vin[3+i]);
            e_next[2][i] = EW'(vin[i]) - EW'(vin[6+i]);
        end
    end

    // Select axis components, magnitudes and the vertex pair of each edge axis
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                a_sel[3*k+j] = (NA[j] != 0) ? -e1_reg[k][CA[j]] : e1_reg[k][CA[j]];
                b_sel[3*k+j] = (NB[j] != 0) ? -e1_reg[k][CB[j]] : e1_reg[k][CB[j]];
                fa[3*k+j] = e1_reg[k][CA[j]][EW-1] ? -e1_reg[k][CA[j]] : e1_reg[k][CA[j]];
                fb[3*k+j] = e1_reg[k][CB[j]][EW-1] ? -e1_reg[k][CB[j]] : e1_reg[k][CB[j]];
                if (j < 2)
                begin
                    pv[3*k+j] = 2'd0;
                    qv[3*k+j] = (k == 2) ? 2'd1 : 2'd2;
                end
                else
                begin
                    pv[3*k+j] = (k == 1) ? 2'd0 : 2'd1;
                    qv[3*k+j] = (k == 1) ? 2'd1 : 2'd2;
                end
            end
        end
    end

    // Form the normal and test each edge axis against the projected radius
    always_comb
    begin
        n_next[0] = NW'(np_reg[0]) - NW'(np_reg[1]);
        n_next[1] = NW'(np_reg[2]) - NW'(np_reg[3]);
        n_next[2] = NW'(np_reg[4]) - NW'(np_reg[5]);
        esep_next = 1'b0;
        for (int i = 0; i < 9; i++)
        begin
            s0[i] = XW'(ep_reg[i][0]) + XW'(ep_reg[i][1]);
            s1[i] = XW'(ep_reg[i][2]) + XW'(ep_reg[i][3]);
            rx[i] = XW'(rad_reg[i]) <<< FRAC_BITS;
            if ((s0[i] > rx[i] && s1[i] > rx[i]) || (s0[i] < -rx[i] && s1[i] < -rx[i]))
                esep_next = 1'b1;
        end
    end

    // Pick nearest and farthest box corner offsets from the normal's signs
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (n3_reg[i] > 0)
            begin
                cor[i][0] = -ONE_N - NCW'(v0_3_reg[i]);
                cor[i][1] = ONE_N - NCW'(v0_3_reg[i]);
            end
            else
            begin
                cor[i][0] = ONE_N - NCW'(v0_3_reg[i]);
                cor[i][1] = -ONE_N - NCW'(v0_3_reg[i]);
            end
        end
    end

    // Recombine the split partial products into the two dot products
    always_comb
    begin
        dmin_next = '0;
        dmax_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            dmin_next = dmin_next + DSW'((DW'(ph_reg[i][0]) <<< L) + DW'(pl_reg[i][0]));
            dmax_next = dmax_next + DSW'((DW'(ph_reg[i][1]) <<< L) + DW'(pl_reg[i][1]));
        end
    end

    assign overlap_next = !face5_reg
                          && (quick || (!esep5_reg && !(dmin_reg > 0) && !dmax_reg[DSW-1]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            b4_valid_reg  <= 1'b0;
            b5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b1_valid_reg  <= pop_valid;
            b2_valid_reg  <= b1_valid_reg;
            b3_valid_reg  <= b2_valid_reg;
            b4_valid_reg  <= b3_valid_reg;
            b5_valid_reg  <= b4_valid_reg;
            out_valid_reg <= b5_valid_reg;
        end
    end

    // Advance the payload pipeline; hold everything while the result waits
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            face1_reg <= pop_data[9*CW];
            v1_reg    <= vin;
            e1_reg    <= e_next;

            face2_reg <= face1_reg;
            for (int i = 0; i < 3; i++)
                v0_2_reg[i] <= v1_reg[i];
            np_reg[0] <= e1_reg[0][1] * e1_reg[1][2];
            np_reg[1] <= e1_reg[0][2] * e1_reg[1][1];
            np_reg[2] <= e1_reg[0][2] * e1_reg[1][0];
            np_reg[3] <= e1_reg[0][0] * e1_reg[1][2];
            np_reg[4] <= e1_reg[0][0] * e1_reg[1][1];
            np_reg[5] <= e1_reg[0][1] * e1_reg[1][0];
            for (int k = 0; k < 3; k++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    ep_reg[3*k+j][0] <= a_sel[3*k+j] * v1_reg[3*pv[3*k+j] + I0[j]];
                    ep_reg[3*k+j][1] <= b_sel[3*k+j] * v1_reg[3*pv[3*k+j] + I1[j]];
                    ep_reg[3*k+j][2] <= a_sel[3*k+j] * v1_reg[3*qv[3*k+j] + I0[j]];
                    ep_reg[3*k+j][3] <= b_sel[3*k+j] * v1_reg[3*qv[3*k+j] + I1[j]];
                    rad_reg[3*k+j]   <= RW'(fa[3*k+j]) + RW'(fb[3*k+j]);
                end
            end

            face3_reg <= face2_reg;
            esep3_reg <= esep_next;
            v0_3_reg  <= v0_2_reg;
            n3_reg    <= n_next;

            face4_reg <= face3_reg;
            esep4_reg <= esep3_reg;
            for (int i = 0; i < 3; i++)
            begin
                for (int c = 0; c < 2; c++)
                begin
                    pl_reg[i][c] <= cor[i][c] * $signed({1'b0, n3_reg[i][L-1:0]});
                    ph_reg[i][c] <= cor[i][c] * $signed(n3_reg[i][NW-1:L]);
                end
            end

            face5_reg <= face4_reg;
            esep5_reg <= esep4_reg;
            dmin_reg  <= dmin_next;
            dmax_reg  <= dmax_next;

            overlap_reg <= overlap_next;
        end
    end

endmodule

>>> rtl/triangle_obb_overlap_test.sv
// Top level of the triangle versus oriented box overlap test.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------
//  input    | in_valid / in_ready   | ax ay az bx by_coord bz cx cy cz
//  output   | out_valid / out_ready | overlap
//  config   | wr_en                 | wr_index, wr_data
//
// One triangle is accepted per cycle while in_ready is high; its result passes
// through two front stages, the first loaded at the accepting edge, one queue
// slot and six back stages.
// The mapping, edge axis and plane products are each registered in a multiplier
// stage. Reset loads the identity transform and the full test.
// A stalled output holds the back part; the four-word queue lets the front
// keep accepting until it fills.
`timescale 1ns / 1ps

module triangle_obb_overlap_test #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    parameter int FIFO_DEPTH  = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [tobb_pkg::CFG_INDEX_W-1:0]    wr_index,
    input  logic [tobb_pkg::CFG_DATA_W-1:0]     wr_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [COORD_WIDTH-1:0]              ax,
    input  logic [COORD_WIDTH-1:0]              ay,
    input  logic [COORD_WIDTH-1:0]              az,
    input  logic [COORD_WIDTH-1:0]              bx,
    input  logic [COORD_WIDTH-1:0]              by_coord,
    input  logic [COORD_WIDTH-1:0]              bz,
    input  logic [COORD_WIDTH-1:0]              cx,
    input  logic [COORD_WIDTH-1:0]              cy,
    input  logic [COORD_WIDTH-1:0]              cz,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                overlap
);

    localparam int QW = 9 * COORD_WIDTH + 1;

    logic [tobb_pkg::CFG_DATA_W-1:0] coef_pair_reg [6];
    logic                            quick_reg;
    tobb_pkg::coef_t                 coef;
    logic [8:0][COORD_WIDTH-1:0]     vtx;
    logic                            push_valid, push_ready;
    logic [QW-1:0]                   push_data;
    logic                            pop_valid, pop_ready;
    logic [QW-1:0]                   pop_data;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_pair_reg[0] <= 64'd65536;
            coef_pair_reg[1] <= 64'd0;
            coef_pair_reg[2] <= 64'd65536;
            coef_pair_reg[3] <= 64'd0;
            coef_pair_reg[4] <= 64'd65536;
            coef_pair_reg[5] <= 64'd0;
            quick_reg        <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_index) inside
                [tobb_pkg::CFG_COEF_PAIR_0:tobb_pkg::CFG_COEF_PAIR_5]:
                    coef_pair_reg[wr_index] <= wr_data;
                tobb_pkg::CFG_QUICK_MODE:
                    quick_reg <= wr_data[0];
                default: ;
            endcase
        end
    end

    // Split register pairs into signed coefficient words
    always_comb
    begin
        coef.m11 = $signed(coef_pair_reg[0][31:0]);
        coef.m12 = $signed(coef_pair_reg[0][63:32]);
        coef.m13 = $signed(coef_pair_reg[1][31:0]);
        coef.m21 = $signed(coef_pair_reg[1][63:32]);
        coef.m22 = $signed(coef_pair_reg[2][31:0]);
        coef.m23 = $signed(coef_pair_reg[2][63:32]);
        coef.m31 = $signed(coef_pair_reg[3][31:0]);
        coef.m32 = $signed(coef_pair_reg[3][63:32]);
        coef.m33 = $signed(coef_pair_reg[4][31:0]);
        coef.tx  = $signed(coef_pair_reg[4][63:32]);
        coef.ty  = $signed(coef_pair_reg[5][31:0]);
        coef.tz  = $signed(coef_pair_reg[5][63:32]);
    end

    assign vtx = {cz, cy, cx, bz, by_coord, bx, az, ay, ax};

    tobb_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .vtx        (vtx),
        .coef       (coef),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    tobb_fifo #(
        .WIDTH (QW),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    tobb_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .quick     (quick_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .overlap   (overlap)
    );

endmodule

>>> rtl/tobb_checker.sv
// Port-level checks for the overlap test, bound to the top level.
`timescale 1ns / 1ps

module tobb_checker #(
    parameter int FIFO_DEPTH = 4
) (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic overlap
);

    localparam int MAX_OUT = FIFO_DEPTH + 8;

    logic [7:0] cnt_reg;

    // Track words accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_reg + 8'(in_valid && in_ready) - 8'(out_valid && out_ready);
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(overlap))
        else $error("stalled result changed or dropped");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cnt_reg != 8'd0)
        else $error("result without an outstanding word");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 8'(MAX_OUT))
        else $error("more words in flight than the pipeline holds");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> cnt_reg >= 8'(FIFO_DEPTH + 1))
        else $error("input stalled while the queue has room");

endmodule

bind triangle_obb_overlap_test tobb_checker #(.FIFO_DEPTH(FIFO_DEPTH)) u_chk (.*);

>>> sim/triangle_obb_overlap_test_tb.sv
// Testbench for the triangle versus oriented box overlap block.
`timescale 1ns / 1ps

module triangle_obb_overlap_test_tb;

    typedef logic signed [31:0]  coord_t;
    typedef logic signed [127:0] acc_t;

    localparam int   FRAC = 16;
    localparam acc_t ONE = acc_t'(1) <<< FRAC;
    localparam acc_t COORD_MAX = 128'sd2147483647;
    localparam acc_t COORD_MIN = -128'sd2147483648;
    localparam logic [tobb_pkg::CFG_INDEX_W-1:0] SPARE_INDEX = 3'd7;
    localparam int   SETTLE_CYCLES = 14;
    localparam int   STALL_LIMIT = 1000;
    localparam coord_t C_ONE = 32'sd65536;

    logic                             clk;
    logic                             rst_n;
    logic                             wr_en;
    logic [tobb_pkg::CFG_INDEX_W-1:0] wr_index;
    logic [tobb_pkg::CFG_DATA_W-1:0]  wr_data;
    logic                             in_valid;
    logic                             in_ready;
    logic [31:0]                      ax, ay, az, bx, by_coord, bz, cx, cy, cz;
    logic                             out_valid;
    logic                             out_ready;
    logic                             overlap;

    // Shadow of the configuration registers
    logic [63:0] coef_reg [6];
    logic        quick_on;

    bit   overlap_q[$];
    int   error_count;
    int   idle_count;
    bit   sender_no_gaps;
    bit   sink_no_stalls;
    int   sink_hold;

    triangle_obb_overlap_test i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .ax       (ax),
        .ay       (ay),
        .az       (az),
        .bx       (bx),
        .by_coord (by_coord),
        .bz       (bz),
        .cx       (cx),
        .cy       (cy),
        .cz       (cz),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .overlap  (overlap)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Sign-extend one 32-bit word
    function automatic acc_t sx(input logic [31:0] w);
        return acc_t'($signed(w));
    endfunction

    function automatic acc_t mag(input acc_t a);
        return (a < 0) ? -a : a;
    endfunction

    // Projection interval of two vertices against the box radius on one edge axis
    function automatic bit axis_splits(input acc_t a, input acc_t b, input acc_t fa,
                                       input acc_t fb, input acc_t p0, input acc_t p1,
                                       input acc_t q0, input acc_t q1);
        acc_t s0, s1, lo, hi, rad;
        s0 = a * p0 + b * p1;
        s1 = a * q0 + b * q1;
        lo = (s0 > s1) ? s1 : s0;
        hi = (s0 > s1) ? s0 : s1;
        rad = (fa + fb) * ONE;
        return (lo > rad) || (-rad > hi);
    endfunction

    // Map the triangle into box space and run the separating axis test
    function automatic bit predict_overlap(input coord_t p[9]);
        acc_t m[3][3];
        acc_t t[3];
        acc_t v[3][3];
        acc_t e[3][3];
        acc_t n[3];
        acc_t f[3];
        acc_t s, dmin, dmax;
        int   k, j, qx, pz, qz;
        bit   pos;
        m[0][0] = sx(coef_reg[0][31:0]);  m[0][1] = sx(coef_reg[0][63:32]);
        m[0][2] = sx(coef_reg[1][31:0]);  m[1][0] = sx(coef_reg[1][63:32]);
        m[1][1] = sx(coef_reg[2][31:0]);  m[1][2] = sx(coef_reg[2][63:32]);
        m[2][0] = sx(coef_reg[3][31:0]);  m[2][1] = sx(coef_reg[3][63:32]);
        m[2][2] = sx(coef_reg[4][31:0]);  t[0]    = sx(coef_reg[4][63:32]);
        t[1]    = sx(coef_reg[5][31:0]);  t[2]    = sx(coef_reg[5][63:32]);
        for (k = 0; k < 3; k++)
        begin
            for (j = 0; j < 3; j++)
            begin
                s = ((sx(p[3*k]) * m[0][j] + sx(p[3*k+1]) * m[1][j]
                      + sx(p[3*k+2]) * m[2][j]) >>> FRAC) + t[j];
                if (s > COORD_MAX) s = COORD_MAX;
                if (s < COORD_MIN) s = COORD_MIN;
                v[k][j] = s;
            end
        end
        // Face planes: all three vertices strictly beyond one face
        for (j = 0; j < 3; j++)
        begin
            if (v[0][j] < -ONE && v[1][j] < -ONE && v[2][j] < -ONE) return 1'b0;
            if (v[0][j] > ONE && v[1][j] > ONE && v[2][j] > ONE) return 1'b0;
        end
        if (quick_on) return 1'b1;
        for (j = 0; j < 3; j++)
        begin
            e[0][j] = v[1][j] - v[0][j];
            e[1][j] = v[2][j] - v[1][j];
            e[2][j] = v[0][j] - v[2][j];
        end
        n[0] = e[0][1] * e[1][2] - e[0][2] * e[1][1];
        n[1] = e[0][2] * e[1][0] - e[0][0] * e[1][2];
        n[2] = e[0][0] * e[1][1] - e[0][1] * e[1][0];
        // Triangle plane against the nearest and farthest box corners
        dmin = 0;
        dmax = 0;
        for (j = 0; j < 3; j++)
        begin
            pos = n[j] > 0;
            dmin += ((pos ? -ONE : ONE) - v[0][j]) * n[j];
            dmax += ((pos ? ONE : -ONE) - v[0][j]) * n[j];
        end
        if (dmin > 0) return 1'b0;
        if (dmax < 0) return 1'b0;
        // Edge cross box axis
        for (k = 0; k < 3; k++)
        begin
            qx = (k == 2) ? 1 : 2;
            pz = (k == 1) ? 0 : 1;
            qz = (k == 1) ? 1 : 2;
            for (j = 0; j < 3; j++) f[j] = mag(e[k][j]);
            if (axis_splits(e[k][2], -e[k][1], f[2], f[1],
                            v[0][1], v[0][2], v[qx][1], v[qx][2])) return 1'b0;
            if (axis_splits(-e[k][2], e[k][0], f[2], f[0],
                            v[0][0], v[0][2], v[qx][0], v[qx][2])) return 1'b0;
            if (axis_splits(e[k][1], -e[k][0], f[1], f[0],
                            v[pz][0], v[pz][1], v[qz][0], v[qz][1])) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Gap length: mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Send one triangle and queue its predicted overlap at acceptance
    task automatic send_triangle(input coord_t p[9]);
        int gap;
        gap = sender_no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        ax <= p[0]; ay <= p[1]; az <= p[2];
        bx <= p[3]; by_coord <= p[4]; bz <= p[5];
        cx <= p[6]; cy <= p[7]; cz <= p[8];
        do @(posedge clk); while (!in_ready);
        overlap_q.push_back(predict_overlap(p));
    endtask

    task automatic send_points(input coord_t a0, a1, a2, b0, b1, b2, c0, c1, c2);
        coord_t p[9];
        p = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
        send_triangle(p);
    endtask

    // Drain the pipeline so a register can be written while idle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (overlap_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [tobb_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [63:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        case (idx)
            tobb_pkg::CFG_COEF_PAIR_0, tobb_pkg::CFG_COEF_PAIR_1,
            tobb_pkg::CFG_COEF_PAIR_2, tobb_pkg::CFG_COEF_PAIR_3,
            tobb_pkg::CFG_COEF_PAIR_4, tobb_pkg::CFG_COEF_PAIR_5: coef_reg[idx] = data;
            tobb_pkg::CFG_QUICK_MODE: quick_on = data[0];
            default: ;
        endcase
    endtask

    task automatic load_transform(input logic [63:0] c0, c1, c2, c3, c4, c5);
        wait_idle();
        write_reg(tobb_pkg::CFG_COEF_PAIR_0, c0);
        write_reg(tobb_pkg::CFG_COEF_PAIR_1, c1);
        write_reg(tobb_pkg::CFG_COEF_PAIR_2, c2);
        write_reg(tobb_pkg::CFG_COEF_PAIR_3, c3);
        write_reg(tobb_pkg::CFG_COEF_PAIR_4, c4);
        write_reg(tobb_pkg::CFG_COEF_PAIR_5, c5);
    endtask

    function automatic coord_t rand_coord();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return coord_t'($urandom);
        if (r == 1) return $urandom_range(0, 1) ? COORD_MAX[31:0] : COORD_MIN[31:0];
        if (r < 5) return coord_t'($urandom_range(0, 40 * 65536)) - 20 * C_ONE;
        return coord_t'($urandom_range(0, 6 * 65536)) - 3 * C_ONE;
    endfunction

    function automatic logic [31:0] rand_coef();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return $urandom;
        if (r == 1) return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
        if (r < 8) return 32'h0;
        return 32'($urandom_range(0, 4 * 65536)) - 32'h0002_0000;
    endfunction

    // Output stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            sink_hold <= 0;
        end
        else if (sink_no_stalls)
        begin
            out_ready <= 1'b1;
        end
        else if (sink_hold > 0)
        begin
            out_ready <= 1'b0;
            sink_hold <= sink_hold - 1;
        end
        else
        begin
            sink_hold <= pick_gap();
            out_ready <= 1'b1;
        end
    end

    // Check each result word against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (overlap_q.size() == 0)
                report_mismatch("result word with no prediction waiting");
            else if (overlap !== overlap_q[0])
            begin
                report_mismatch($sformatf("overlap %b, predicted %b", overlap, overlap_q[0]));
                void'(overlap_q.pop_front());
            end
            else
                void'(overlap_q.pop_front());
        end
    end

    // Watchdog: count cycles with work outstanding and no handshake
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)
            || (overlap_q.size() == 0 && !in_valid))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT)
        begin
            $display("triangle_obb_overlap_test: mismatch");
            $finish;
        end
    end

    // Identity transform: faces, triangle plane, extremes, degenerate shapes
    task automatic test_directed_full();
        coord_t h, m2, mx, mn;
        h  = C_ONE / 2;
        m2 = 2 * C_ONE;
        mx = COORD_MAX[31:0];
        mn = COORD_MIN[31:0];
        send_points(0, 0, 0, h, 0, 0, 0, h, 0);
        send_points(m2, 0, 0, m2, h, 0, m2, 0, h);
        send_points(-m2, 0, 0, -m2, h, 0, -m2, 0, h);
        send_points(0, m2, 0, h, m2, 0, 0, m2, h);
        send_points(0, 0, -m2, h, 0, -m2, 0, h, -m2);
        send_points(C_ONE, 0, 0, C_ONE, h, 0, C_ONE, 0, h);
        send_points(C_ONE + 1, 0, 0, C_ONE + 1, h, 0, C_ONE + 1, 0, h);
        send_points(mx, mx, mx, mx, mx, mx, mx, mx, mx);
        send_points(mn, mn, mn, mx, mn, 0, 0, mx, mx);
        send_points(mn, 0, 0, mx, 0, 0, 0, 0, 0);
        send_points(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_points(3 * C_ONE, 0, 0, 3 * C_ONE, 0, 0, 3 * C_ONE, 0, 0);
        send_points(7 * h, 0, 0, 0, 7 * h, 0, 0, 0, 7 * h);
        send_points(5 * h, -h, 0, -h, 5 * h, 0, 5 * h, 5 * h, h);
        send_points(-m2, h, 3 * h, h, -m2, 3 * h, m2, m2, -3 * h);
        send_points(-1, -1, -1, -1, -1, -1, 0, 0, 0);
    endtask

    // Face planes only: the plane and edge separations are no longer seen
    task automatic test_quick_mode();
        coord_t h;
        h = C_ONE / 2;
        wait_idle();
        write_reg(tobb_pkg::CFG_QUICK_MODE, 64'hffff_ffff_ffff_ffff);
        send_points(7 * h, 0, 0, 0, 7 * h, 0, 0, 0, 7 * h);
        send_points(5 * h, -h, 0, -h, 5 * h, 0, 5 * h, 5 * h, h);
        send_points(C_ONE + 1, 0, 0, C_ONE + 1, h, 0, C_ONE + 1, 0, h);
        wait_idle();
        write_reg(tobb_pkg::CFG_QUICK_MODE, 64'hffff_ffff_ffff_fffe);
        write_reg(SPARE_INDEX, 64'hffff_ffff_ffff_ffff);
    endtask

    // Extreme coefficients: saturation of the mapped coordinates
    task automatic test_extreme_transform();
        load_transform(64'h8000_0000_7fff_ffff, 64'h7fff_ffff_8000_0000,
                       64'hffff_ffff_ffff_ffff, 64'h8000_0000_8000_0000,
                       64'h7fff_ffff_7fff_ffff, 64'h8000_0000_7fff_ffff);
        send_points(C_ONE, -C_ONE, 1, 0, 0, 0, -1, C_ONE / 3, 0);
        send_points(COORD_MAX[31:0], COORD_MIN[31:0], 0, 0, 0, 0, 1, 1, 1);
        load_transform(64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0);
        send_points(C_ONE, C_ONE, C_ONE, -C_ONE, 5, 9, 0, 0, COORD_MAX[31:0]);
    endtask

    // Random phases, each with its own transform, mode and handshake pressure
    task automatic test_random_phases();
        coord_t p[9];
        int phase, i, j;
        for (phase = 0; phase < 8; phase++)
        begin
            if (phase == 0)
                load_transform(64'h0000_0000_0001_0000, 64'h0, 64'h0000_0000_0001_0000,
                               64'h0, 64'h0000_0000_0001_0000, 64'h0);
            else
                load_transform({rand_coef(), rand_coef()}, {rand_coef(), rand_coef()},
                               {rand_coef(), rand_coef()}, {rand_coef(), rand_coef()},
                               {rand_coef(), rand_coef()}, {rand_coef(), rand_coef()});
            write_reg(tobb_pkg::CFG_QUICK_MODE, {63'($urandom), phase % 3 == 2});
            sender_no_gaps = (phase % 4 == 1);
            sink_no_stalls = (phase % 4 == 3);
            for (i = 0; i < 185; i++)
            begin
                for (j = 0; j < 9; j++) p[j] = rand_coord();
                send_triangle(p);
            end
        end
        sender_no_gaps = 1'b0;
        sink_no_stalls = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        in_valid = 1'b0;
        {ax, ay, az, bx, by_coord, bz, cx, cy, cz} = '0;
        coef_reg = '{64'd65536, 64'd0, 64'd65536, 64'd0, 64'd65536, 64'd0};
        quick_on = 1'b0;
        error_count = 0;
        idle_count = 0;
        sender_no_gaps = 1'b0;
        sink_no_stalls = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_full();
        test_quick_mode();
        test_extreme_transform();
        test_random_phases();

        wait_idle();
        if (error_count == 0)
            $display("triangle_obb_overlap_test: match");
        else
            $display("triangle_obb_overlap_test: mismatch");
        $finish;
    end

endmodule

>>> files.f
rtl/tobb_pkg.sv
rtl/tobb_fifo.sv
rtl/tobb_front.sv
rtl/tobb_back.sv
rtl/triangle_obb_overlap_test.sv
rtl/tobb_checker.sv
sim/triangle_obb_overlap_test_tb.sv
